### src/bstm_pkg.sv
// ----------------------------------------------------------------------------
// bstm_pkg
// Shared types and constants for the block signature table.
// ----------------------------------------------------------------------------
package bstm_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   localparam int OP_W     = 1;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 24;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = 9;
   localparam int SUM_W    = 16;
   localparam int HASH_W   = 32;

   localparam logic [HASH_W-1:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [HASH_W-1:0] FNV_PRIME  = 32'd16777619;

   localparam logic [OP_W-1:0] OP_ADD   = 1'b0;
   localparam logic [OP_W-1:0] OP_MATCH = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MATCH   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

   // search key traveling down the cell row
   typedef struct packed {
      logic                valid;
      logic [HASH_W-1:0]   weak_sum;
      logic [HASH_W-1:0]   strong_sum;
      logic                found;
      logic [INDEX_W-1:0]  index;
   } tok_type;

   // entry write, broadcast to all cells
   typedef struct packed {
      logic                en;
      logic [HASH_W-1:0]   weak_sum;
      logic [HASH_W-1:0]   strong_sum;
      logic [INDEX_W-1:0]  index;
   } wr_type;

endpackage

### src/block_signature_table_match.sv
// ----------------------------------------------------------------------------
// block_signature_table_match
// Block signature table: rsync weak checksum plus FNV-1a hash per block,
// appended to a table on add, looked up on match.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while req_stall is low. An add block reports
// on the cycle after its last byte. A match block sends its signature from
// the key register down a row of TABLE_ENTRIES cells, one cell per cycle,
// and through the tail register into the result register; req_stall stays
// high until that result is loaded. A last byte is also held off while an
// earlier result is still waiting on rsp_stall. The table needs no clearing
// after reset: the fill count alone marks live entries.
module block_signature_table_match
   import bstm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                req_last_byte,
   input  logic [INDEX_W-1:0]  req_block_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [INDEX_W-1:0]  rsp_match_index,
   output logic [ENTRY_W-1:0]  rsp_entry_count,
   output logic [HASH_W-1:0]   rsp_weak_sum,
   output logic [HASH_W-1:0]   rsp_strong_sum
);

   logic              req_beat, add_done, match_start, full, rsp_free, tail_load;
   logic [HASH_W-1:0] weak_sum, strong_sum;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              busy_ff, busy_in;
   tok_type           key_ff, key_in;
   tok_type           tail_ff, tail_in;
   tok_type           chain_tok [TABLE_ENTRIES+1];
   wr_type            wr;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [INDEX_W-1:0]  mindex_ff, mindex_in;
   logic [CNT_W-1:0]    rcount_ff, rcount_in;
   logic [HASH_W-1:0]   weak_ff, weak_in;
   logic [HASH_W-1:0]   strong_ff, strong_in;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy_ff || (req_last_byte && rsp_valid_ff && rsp_stall);
   assign req_beat  = req_valid && !req_stall;

   assign add_done    = req_beat && req_last_byte && (req_op == OP_ADD);
   assign match_start = req_beat && req_last_byte && (req_op == OP_MATCH);
   assign full        = (count_ff >= CNT_W'(TABLE_ENTRIES));
   assign tail_load   = tail_ff.valid && rsp_free;

   bstm_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .beat       (req_beat),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .weak_sum   (weak_sum),
      .strong_sum (strong_sum)
   );

   assign wr.en         = add_done && !full;
   assign wr.weak_sum   = weak_sum;
   assign wr.strong_sum = strong_sum;
   assign wr.index      = req_block_index;

   always_comb begin
      key_in.valid      = match_start;
      key_in.weak_sum   = weak_sum;
      key_in.strong_sum = strong_sum;
      key_in.found      = 1'b0;
      key_in.index      = '0;
   end

   assign chain_tok[0] = key_ff;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      bstm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_id (CNT_W'(g)),
         .count   (count_ff),
         .wr      (wr),
         .tok_in  (chain_tok[g]),
         .tok_out (chain_tok[g+1])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (wr.en) begin
         count_in = count_ff + CNT_W'(1);
      end

      busy_in = busy_ff;
      if (match_start) begin
         busy_in = 1'b1;
      end else if (tail_load) begin
         busy_in = 1'b0;
      end

      tail_in = tail_ff;
      if (chain_tok[TABLE_ENTRIES].valid) begin
         tail_in = chain_tok[TABLE_ENTRIES];
      end else if (tail_load) begin
         tail_in.valid = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      mindex_in    = mindex_ff;
      rcount_in    = rcount_ff;
      weak_in      = weak_ff;
      strong_in    = strong_ff;
      if (add_done) begin
         rsp_valid_in = 1'b1;
         status_in    = full ? ST_FULL : ST_ADDED;
         mindex_in    = '0;
         rcount_in    = count_in;
         weak_in      = weak_sum;
         strong_in    = strong_sum;
      end else if (tail_load) begin
         rsp_valid_in = 1'b1;
         status_in    = tail_ff.found ? ST_MATCH : ST_NOMATCH;
         mindex_in    = tail_ff.index;
         rcount_in    = count_ff;
         weak_in      = tail_ff.weak_sum;
         strong_in    = tail_ff.strong_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         key_ff.valid <= 1'b0;
         tail_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         key_ff       <= key_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      mindex_ff <= mindex_in;
      rcount_ff <= rcount_in;
      weak_ff   <= weak_in;
      strong_ff <= strong_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_match_index = mindex_ff;
   assign rsp_entry_count = ENTRY_W'(rcount_ff);
   assign rsp_weak_sum    = weak_ff;
   assign rsp_strong_sum  = strong_ff;

endmodule

### src/bstm_accum.sv
// ----------------------------------------------------------------------------
// bstm_accum
// Running weak checksum (a, b) and FNV-1a hash over the bytes of a block.
// ----------------------------------------------------------------------------
module bstm_accum
   import bstm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              beat,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              last_byte,
   output logic [HASH_W-1:0] weak_sum,
   output logic [HASH_W-1:0] strong_sum
);

   logic [SUM_W-1:0]  sum_a_ff, sum_a_in, a_new;
   logic [SUM_W-1:0]  sum_b_ff, sum_b_in, b_new;
   logic [HASH_W-1:0] hash_ff, hash_in, h_mix, h_new;

   assign a_new = sum_a_ff + {{(SUM_W-BYTE_W){1'b0}}, data_byte};
   assign b_new = sum_b_ff + a_new;
   assign h_mix = hash_ff ^ {{(HASH_W-BYTE_W){1'b0}}, data_byte};
   // constant multiplier: reduces to a few shifted adds
   assign h_new = HASH_W'(h_mix * FNV_PRIME);

   assign weak_sum   = {b_new, a_new};
   assign strong_sum = h_new;

   always_comb begin
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      hash_in  = hash_ff;
      if (beat) begin
         if (last_byte) begin
            sum_a_in = '0;
            sum_b_in = '0;
            hash_in  = FNV_OFFSET;
         end else begin
            sum_a_in = a_new;
            sum_b_in = b_new;
            hash_in  = h_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         hash_ff  <= FNV_OFFSET;
      end else begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         hash_ff  <= hash_in;
      end
   end

endmodule

### src/bstm_cell.sv
// ----------------------------------------------------------------------------
// bstm_cell
// One table entry. Compares the passing key against its entry and hands the
// key to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module bstm_cell
   import bstm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] cell_id,
   input  logic [CNT_W-1:0] count,
   input  wr_type           wr,
   input  tok_type          tok_in,
   output tok_type          tok_out
);

   logic [HASH_W-1:0]  weak_ff;
   logic [HASH_W-1:0]  strong_ff;
   logic [INDEX_W-1:0] index_ff;
   tok_type            tok_ff, tok_in_next;
   logic               hit;

   // entries at or above count were never written for this fill
   assign hit = tok_in.valid && !tok_in.found && (cell_id < count)
                && (weak_ff == tok_in.weak_sum) && (strong_ff == tok_in.strong_sum);

   always_comb begin
      tok_in_next = tok_in;
      if (hit) begin
         tok_in_next.found = 1'b1;
         tok_in_next.index = index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (count == cell_id)) begin
         weak_ff   <= wr.weak_sum;
         strong_ff <= wr.strong_sum;
         index_ff  <= wr.index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

### src/bstm_checker.sv
// ----------------------------------------------------------------------------
// bstm_checker
// Port-level checks for the block signature table.
// ----------------------------------------------------------------------------
module bstm_checker
   import bstm_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [OP_W-1:0]     req_op,
   input logic [BYTE_W-1:0]   req_data_byte,
   input logic                req_last_byte,
   input logic [INDEX_W-1:0]  req_block_index,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [INDEX_W-1:0]  rsp_match_index,
   input logic [ENTRY_W-1:0]  rsp_entry_count,
   input logic [HASH_W-1:0]   rsp_weak_sum,
   input logic [HASH_W-1:0]   rsp_strong_sum
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_match_index) && $stable(rsp_weak_sum)
         && $stable(rsp_strong_sum))
      else $error("result changed while stalled");

   // only a found match carries an index
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_MATCH) |-> rsp_match_index == '0)
      else $error("nonzero match_index without a match");

   // a rejected add means the table is at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL)
         |-> rsp_entry_count == ENTRY_W'(TABLE_ENTRIES))
      else $error("full reported below capacity");

   // add results answer the last byte of an add block on the next edge
   a_add_timing: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && ((rsp_status == ST_ADDED) || (rsp_status == ST_FULL))
         |-> $past(req_valid && !req_stall && req_last_byte && (req_op == OP_ADD)))
      else $error("add result without a preceding add block end");

endmodule

bind block_signature_table_match bstm_checker u_bstm_checker (.*);
